// ===== rtl/core/hsv_to_rgb_converter_top_defines.svh =====
// assertion macros for the hsv to rgb converter
`ifndef HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH

// condition must hold whenever the antecedent holds, same cycle
`define H2R_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// condition must hold in the cycle after the antecedent
`define H2R_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/hsv2rgb_pkg.sv =====
// shared types and constants for the hsv to rgb converter
`default_nettype none

package hsv2rgb_pkg;

    localparam int HUE_BITS    = 9;
    localparam int FRAC_BITS   = 6;
    localparam int SECTOR_BITS = 3;
    localparam int SECTOR_DEG  = 60;
    localparam int FULL_CIRCLE = 360;

    typedef logic [HUE_BITS-1:0]  t_hue;
    typedef logic [FRAC_BITS-1:0] t_frac;

    // named by which channel carries chroma and which carries the ramp
    typedef enum logic [SECTOR_BITS-1:0] {
        SEC_RG = 3'd0,
        SEC_GR = 3'd1,
        SEC_GB = 3'd2,
        SEC_BG = 3'd3,
        SEC_BR = 3'd4,
        SEC_RB = 3'd5
    } t_sector;

endpackage

`default_nettype wire

// ===== rtl/core/hsv_to_rgb_converter_top.sv =====
// hsv to rgb pixel converter, five stage pipeline
//
//   channel  valid         ready         payload
//   input    i_in_valid    o_in_ready    i_hue_deg, i_saturation, i_brightness
//   output   o_out_valid   i_out_ready   o_red, o_green, o_blue
//
// one pixel per cycle sustained while the output is not stalled; each result is registered at every stage
// stages: hue sector and s*v product, chroma by divide-by-max, ramp product,
// ramp divide-by-60 via reciprocal multiply, channel select with offset and clamp
// each stage holds only while every stage after it is full and the output stalls
// synchronous active-low reset clears the stage valid bits only
`default_nettype none

module hsv_to_rgb_converter_top #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [hsv2rgb_pkg::HUE_BITS-1:0] i_hue_deg,
    input  wire logic [CHANNEL_BITS-1:0]         i_saturation,
    input  wire logic [CHANNEL_BITS-1:0]         i_brightness,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [CHANNEL_BITS-1:0]              o_red,
    output logic [CHANNEL_BITS-1:0]              o_green,
    output logic [CHANNEL_BITS-1:0]              o_blue
);

    import hsv2rgb_pkg::*;

`include "hsv_to_rgb_converter_top_defines.svh"

    localparam int CB          = CHANNEL_BITS;
    localparam int PROD_BITS   = 2 * CB;
    // c*k + 30 stays below 64 * 2^CB
    localparam int RAMP_BITS   = CB + FRAC_BITS;
    localparam int RECIP_SHIFT = RAMP_BITS + FRAC_BITS;
    localparam int RECIP_BITS  = RECIP_SHIFT - FRAC_BITS + 1;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RECIP_SHIFT) + SECTOR_DEG - 1) / SECTOR_DEG;
    localparam logic [RECIP_BITS-1:0] RECIP    = RECIP_BITS'(RECIP_L);
    localparam int QUOT_BITS   = RAMP_BITS + RECIP_BITS;
    localparam logic [CB-1:0]  MAXV     = '1;
    localparam logic [CB-1:0]  HALF_MAX = MAXV >> 1;

    // stage advance chain
    logic adv1, adv2, adv3, adv4, adv5;

    // stage 1 registers
    logic                 r_v1;
    t_sector              r_sec1;
    t_frac                r_frac1;
    logic [PROD_BITS-1:0] r_prod1;
    logic [CB-1:0]        r_val1;

    // stage 2 registers
    logic          r_v2;
    t_sector       r_sec2;
    logic [CB-1:0] r_c2;
    logic [CB-1:0] r_m2;
    t_frac         r_k2;

    // stage 3 registers
    logic                 r_v3;
    t_sector              r_sec3;
    logic [CB-1:0]        r_c3;
    logic [CB-1:0]        r_m3;
    logic [RAMP_BITS-1:0] r_ramp3;

    // stage 4 registers
    logic          r_v4;
    t_sector       r_sec4;
    logic [CB-1:0] r_c4;
    logic [CB-1:0] r_m4;
    logic [CB-1:0] r_x4;

    // output registers
    logic          r_v5;
    logic [CB-1:0] r_red5;
    logic [CB-1:0] r_green5;
    logic [CB-1:0] r_blue5;

    // combinational next values
    t_hue                 hue_w;
    t_hue                 hue_base;
    t_sector              n_sec1;
    t_frac                n_frac1;
    logic [PROD_BITS-1:0] n_prod1;
    logic [PROD_BITS-1:0] prod_rnd;
    logic [PROD_BITS:0]   c_sum;
    logic [CB-1:0]        n_c2;
    logic [CB-1:0]        n_m2;
    t_frac                n_k2;
    logic [RAMP_BITS-1:0] n_ramp3;
    logic [QUOT_BITS-1:0] quot_full;
    logic [CB-1:0]        n_x4;
    logic [CB-1:0]        sel_r, sel_g, sel_b;
    logic [CB:0]          sum_r, sum_g, sum_b;
    logic [CB-1:0]        n_red5, n_green5, n_blue5;

    always_comb begin
        adv5       = !r_v5 || i_out_ready;
        adv4       = !r_v4 || adv5;
        adv3       = !r_v3 || adv4;
        adv2       = !r_v2 || adv3;
        adv1       = !r_v1 || adv2;
        o_in_ready = adv1;
    end

    // stage 1: wrap hue, split into sector and offset, form s*v
    always_comb begin
        hue_w = (i_hue_deg >= HUE_BITS'(FULL_CIRCLE))
              ? i_hue_deg - HUE_BITS'(FULL_CIRCLE) : i_hue_deg;
        priority if (hue_w >= HUE_BITS'(5 * SECTOR_DEG)) begin
            n_sec1   = SEC_RB;
            hue_base = HUE_BITS'(5 * SECTOR_DEG);
        end else if (hue_w >= HUE_BITS'(4 * SECTOR_DEG)) begin
            n_sec1   = SEC_BR;
            hue_base = HUE_BITS'(4 * SECTOR_DEG);
        end else if (hue_w >= HUE_BITS'(3 * SECTOR_DEG)) begin
            n_sec1   = SEC_BG;
            hue_base = HUE_BITS'(3 * SECTOR_DEG);
        end else if (hue_w >= HUE_BITS'(2 * SECTOR_DEG)) begin
            n_sec1   = SEC_GB;
            hue_base = HUE_BITS'(2 * SECTOR_DEG);
        end else if (hue_w >= HUE_BITS'(SECTOR_DEG)) begin
            n_sec1   = SEC_GR;
            hue_base = HUE_BITS'(SECTOR_DEG);
        end else begin
            n_sec1   = SEC_RG;
            hue_base = '0;
        end
        n_frac1 = FRAC_BITS'(hue_w - hue_base);
        n_prod1 = PROD_BITS'(i_saturation) * PROD_BITS'(i_brightness);
    end

    // stage 2: rounded divide by 2^n-1 as (t + (t >> n) + 1) >> n
    always_comb begin
        prod_rnd = r_prod1 + PROD_BITS'(HALF_MAX);
        c_sum    = (PROD_BITS+1)'(prod_rnd) + (PROD_BITS+1)'(prod_rnd >> CB)
                 + (PROD_BITS+1)'(1);
        n_c2     = CB'(c_sum >> CB);
        n_m2     = r_val1 - n_c2;
        // odd sectors ramp down
        n_k2     = r_sec1[0] ? FRAC_BITS'(SECTOR_DEG) - r_frac1 : r_frac1;
    end

    // stage 3: ramp numerator with half for rounding
    always_comb begin
        n_ramp3 = RAMP_BITS'(r_c2) * RAMP_BITS'(r_k2) + RAMP_BITS'(SECTOR_DEG / 2);
    end

    // stage 4: divide by 60 through reciprocal multiply
    always_comb begin
        quot_full = QUOT_BITS'(r_ramp3) * QUOT_BITS'(RECIP);
        n_x4      = CB'(quot_full >> RECIP_SHIFT);
    end

    // stage 5: place chroma and ramp, add offset, clamp
    always_comb begin
        unique case (r_sec4)
            SEC_RG: begin
                sel_r = r_c4; sel_g = r_x4; sel_b = '0;
            end
            SEC_GR: begin
                sel_r = r_x4; sel_g = r_c4; sel_b = '0;
            end
            SEC_GB: begin
                sel_r = '0;   sel_g = r_c4; sel_b = r_x4;
            end
            SEC_BG: begin
                sel_r = '0;   sel_g = r_x4; sel_b = r_c4;
            end
            SEC_BR: begin
                sel_r = r_x4; sel_g = '0;   sel_b = r_c4;
            end
            default: begin
                sel_r = r_c4; sel_g = '0;   sel_b = r_x4;
            end
        endcase
        sum_r    = {1'b0, sel_r} + {1'b0, r_m4};
        sum_g    = {1'b0, sel_g} + {1'b0, r_m4};
        sum_b    = {1'b0, sel_b} + {1'b0, r_m4};
        n_red5   = sum_r[CB] ? MAXV : sum_r[CB-1:0];
        n_green5 = sum_g[CB] ? MAXV : sum_g[CB-1:0];
        n_blue5  = sum_b[CB] ? MAXV : sum_b[CB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
            if (adv5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_in_valid) begin
            r_sec1  <= n_sec1;
            r_frac1 <= n_frac1;
            r_prod1 <= n_prod1;
            r_val1  <= i_brightness;
        end
        if (adv2 && r_v1) begin
            r_sec2 <= r_sec1;
            r_c2   <= n_c2;
            r_m2   <= n_m2;
            r_k2   <= n_k2;
        end
        if (adv3 && r_v2) begin
            r_sec3  <= r_sec2;
            r_c3    <= r_c2;
            r_m3    <= r_m2;
            r_ramp3 <= n_ramp3;
        end
        if (adv4 && r_v3) begin
            r_sec4 <= r_sec3;
            r_c4   <= r_c3;
            r_m4   <= r_m3;
            r_x4   <= n_x4;
        end
        if (adv5 && r_v4) begin
            r_red5   <= n_red5;
            r_green5 <= n_green5;
            r_blue5  <= n_blue5;
        end
    end

    assign o_out_valid = r_v5;
    assign o_red       = r_red5;
    assign o_green     = r_green5;
    assign o_blue      = r_blue5;

    `H2R_ASSERT_IMP(a_chroma_within_value, r_v1, n_c2 <= r_val1, "chroma exceeds value")
    `H2R_ASSERT_IMP(a_frac_in_sector, r_v1, r_frac1 < FRAC_BITS'(SECTOR_DEG), "offset out of sector")
    `H2R_ASSERT_IMP(a_ramp_within_chroma, r_v4, r_x4 <= r_c4, "ramp exceeds chroma")
    `H2R_ASSERT_IMP(a_blocked_only_when_full, !o_in_ready, r_v1 && r_v2 && r_v3 && r_v4 && r_v5, "input blocked with a bubble in the pipe")
    `H2R_ASSERT_NXT(a_stall_keeps_result, r_v5 && !i_out_ready, r_v5, "stalled result dropped")

endmodule

`default_nettype wire
